// ===== rtl/sha256c_pkg.sv =====
package sha256c_pkg;

  localparam int unsigned WORD_W      = 32;
  localparam int unsigned CHAIN_WORDS = 8;
  localparam int unsigned WINDOW_LEN  = 16;
  localparam int unsigned ROUNDS      = 64;

  localparam logic [3:0] LAST_WORD  = 4'd15;
  localparam logic [5:0] LAST_ROUND = 6'd63;
  localparam logic [2:0] LAST_INDEX = 3'd7;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_ROUND,
    ST_ADD,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] c;
    logic [WORD_W-1:0] d;
    logic [WORD_W-1:0] e;
    logic [WORD_W-1:0] f;
    logic [WORD_W-1:0] g;
    logic [WORD_W-1:0] h;
  } work_vars_t;

  localparam logic [WORD_W-1:0] ROUND_K [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [WORD_W-1:0] INIT_HASH [CHAIN_WORDS] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [WORD_W-1:0] big_sigma0(input logic [WORD_W-1:0] x);
    return ((x >> 2) | (x << 30)) ^ ((x >> 13) | (x << 19)) ^ ((x >> 22) | (x << 10));
  endfunction

  function automatic logic [WORD_W-1:0] big_sigma1(input logic [WORD_W-1:0] x);
    return ((x >> 6) | (x << 26)) ^ ((x >> 11) | (x << 21)) ^ ((x >> 25) | (x << 7));
  endfunction

  function automatic logic [WORD_W-1:0] small_sigma0(input logic [WORD_W-1:0] x);
    return ((x >> 7) | (x << 25)) ^ ((x >> 18) | (x << 14)) ^ (x >> 3);
  endfunction

  function automatic logic [WORD_W-1:0] small_sigma1(input logic [WORD_W-1:0] x);
    return ((x >> 17) | (x << 15)) ^ ((x >> 19) | (x << 13)) ^ (x >> 10);
  endfunction

endpackage

// ===== rtl/sha256c_round.sv =====
module sha256c_round (
  input  sha256c_pkg::work_vars_t vars,
  input  logic [31:0]             w,
  input  logic [31:0]             k,
  output sha256c_pkg::work_vars_t vars_next
);
  import sha256c_pkg::*;

  logic [WORD_W-1:0] ch;
  logic [WORD_W-1:0] maj;
  logic [WORD_W-1:0] t1;
  logic [WORD_W-1:0] t2;

  always_comb begin
    ch  = (vars.e & vars.f) ^ (~vars.e & vars.g);
    maj = (vars.a & vars.b) ^ (vars.a & vars.c) ^ (vars.b & vars.c);
    t1  = vars.h + big_sigma1(vars.e) + ch + k + w;
    t2  = big_sigma0(vars.a) + maj;
    vars_next.h = vars.g;
    vars_next.g = vars.f;
    vars_next.f = vars.e;
    vars_next.e = vars.d + t1;
    vars_next.d = vars.c;
    vars_next.c = vars.b;
    vars_next.b = vars.a;
    vars_next.a = t1 + t2;
  end

endmodule

// ===== rtl/sha256_block_compress.sv =====
// Channel | Beat fields (lowest bit up)                  | Marks
// s_*     | tdata: message_word[31:0]                    | tuser: start_message
// m_*     | tdata: digest_word[31:0], digest_index[34:32] | tlast: digest_last
//
// A block takes 16 input beats, one per cycle while s_tready is high, then
// 64 rounds on the shared round unit at one per cycle, the chaining add and
// 8 output beats, which stall while m_tready is low. s_tready is low from the
// sixteenth word until the last output beat is taken. rst (synchronous) loads
// the initial hash value and empties the block in progress.
module sha256_block_compress (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // message_word
  input  logic        s_tuser,  // start_message
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,  // digest_word, digest_index, zero fill
  output logic        m_tlast   // digest_last
);
  import sha256c_pkg::*;

  state_t state;
  state_t state_next;

  logic [WORD_W-1:0] chain  [CHAIN_WORDS];
  logic [WORD_W-1:0] window [WINDOW_LEN];
  work_vars_t        vars;
  work_vars_t        vars_next;
  logic [3:0]        word_count;
  logic [5:0]        round_count;
  logic [2:0]        emit_idx;
  logic [WORD_W-1:0] w_new;

  logic s_beat;
  logic m_beat;

  assign s_beat = s_tvalid && s_tready;
  assign m_beat = m_tvalid && m_tready;

  assign w_new = small_sigma1(window[14]) + window[9] + small_sigma0(window[1]) + window[0];

  sha256c_round u_round (
    .vars      (vars),
    .w         (window[0]),
    .k         (ROUND_K[round_count]),
    .vars_next (vars_next)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD: begin
        if (s_beat && !s_tuser && word_count == LAST_WORD) state_next = ST_ROUND;
      end
      ST_ROUND: begin
        if (round_count == LAST_ROUND) state_next = ST_ADD;
      end
      ST_ADD: state_next = ST_EMIT;
      ST_EMIT: begin
        if (m_beat && emit_idx == LAST_INDEX) state_next = ST_LOAD;
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    m_tvalid = 1'b0;
    case (state)
      ST_LOAD: s_tready = 1'b1;
      ST_EMIT: m_tvalid = 1'b1;
      default: ;
    endcase
  end

  assign m_tdata = {5'd0, emit_idx, chain[emit_idx]};
  assign m_tlast = (emit_idx == LAST_INDEX);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_LOAD;
      word_count  <= '0;
      round_count <= '0;
      emit_idx    <= '0;
    end else begin
      state <= state_next;
      if (s_beat) word_count <= s_tuser ? 4'd1 : word_count + 4'd1;
      if (state == ST_ROUND) round_count <= round_count + 6'd1;
      if (m_beat) emit_idx <= emit_idx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHAIN_WORDS; i++) chain[i] <= INIT_HASH[i];
    end else if (s_beat && s_tuser) begin
      for (int i = 0; i < CHAIN_WORDS; i++) chain[i] <= INIT_HASH[i];
    end else if (state == ST_ADD) begin
      chain[0] <= chain[0] + vars.a;
      chain[1] <= chain[1] + vars.b;
      chain[2] <= chain[2] + vars.c;
      chain[3] <= chain[3] + vars.d;
      chain[4] <= chain[4] + vars.e;
      chain[5] <= chain[5] + vars.f;
      chain[6] <= chain[6] + vars.g;
      chain[7] <= chain[7] + vars.h;
    end
  end

  // shift the schedule: oldest word sits at the bottom
  always_ff @(posedge clk) begin
    if (s_beat) begin
      for (int i = 0; i < WINDOW_LEN - 1; i++) window[i] <= window[i + 1];
      window[WINDOW_LEN - 1] <= s_tdata;
    end else if (state == ST_ROUND) begin
      for (int i = 0; i < WINDOW_LEN - 1; i++) window[i] <= window[i + 1];
      window[WINDOW_LEN - 1] <= w_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vars <= '0;
    end else if (state == ST_LOAD && state_next == ST_ROUND) begin
      vars <= '{a: chain[0], b: chain[1], c: chain[2], d: chain[3],
                e: chain[4], f: chain[5], g: chain[6], h: chain[7]};
    end else if (state == ST_ROUND) begin
      vars <= vars_next;
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input and output open together");

  a_rounds_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND && round_count == LAST_ROUND) |=> (state == ST_ADD && round_count == '0))
    else $error("round count out of step");

  a_back_to_load: assert property (@(posedge clk) disable iff (rst)
    (m_beat && m_tlast) |=> (s_tready && emit_idx == '0))
    else $error("no return to load after last beat");

  a_block_start: assert property (@(posedge clk) disable iff (rst)
    (s_beat && !s_tuser && word_count == LAST_WORD) |=> (state == ST_ROUND && round_count == '0))
    else $error("rounds not started after sixteenth word");

endmodule
